/* hdl/shs_pkg.sv */
// Package for the byte-serial SHA-256 hasher.
// Holds the state encoding, round constants, initial hash and round functions.
// Depends on nothing.
`timescale 1ns / 1ps

package shs_pkg;

  typedef enum logic [7:0] {
    ST_INIT = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_PAD  = 8'b0000_0100,
    ST_LDH  = 8'b0000_1000,
    ST_RND  = 8'b0001_0000,
    ST_ADD  = 8'b0010_0000,
    ST_ORD  = 8'b0100_0000,
    ST_OLD  = 8'b1000_0000
  } state_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

/* hdl/shs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module shs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/sha256_stream_hasher_top.sv */
// Top level of the byte-serial SHA-256 hasher.
// Depends on shs_pkg and shs_ram.
`timescale 1ns / 1ps

// Message bytes are taken one per cycle while the engine is idle and are packed into a
// 16-word block memory. A full block stops input while the chaining words are loaded
// from their memory, the 64 rounds run with a 16-word schedule window, and the result
// is added back. On last, padding bytes go in one per cycle through the same path, then
// the eight digest words come out, read from the chaining memory.
// After reset a pass writes the initial hash before the first request is taken.
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  shs_pkg::state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic        fin_r, fin_nxt;
  logic        final_r, final_nxt;
  logic        first_r, first_nxt;
  logic        extra_r, extra_nxt;
  logic [31:0] v_r [0:7];
  logic [31:0] w_r [0:15];
  logic        ovalid_r;
  logic [31:0] oword_r;
  logic [2:0]  oidx_r;
  logic        olast_r;

  logic        byte_we;
  logic [7:0]  byte_val;
  logic        blk_we;
  logic [3:0]  blk_waddr, blk_raddr;
  logic [31:0] blk_wdata, blk_rdata;
  logic        ch_we;
  logic [2:0]  ch_waddr, ch_raddr;
  logic [31:0] ch_wdata, ch_rdata;
  logic [31:0] w_cur, t1, t2;
  logic [63:0] len_shift;
  logic        in_acc;

  shs_ram #(.WIDTH(32), .DEPTH(16)) u_blk (
    .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
    .raddr(blk_raddr), .rdata(blk_rdata)
  );

  shs_ram #(.WIDTH(32), .DEPTH(8)) u_chain (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  assign in_ready = (state_r == shs_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign len_shift = bitlen_r << {fill_r[2:0], 3'b000};

  always_comb begin
    w_cur = (cnt_r < 6'd16) ? blk_rdata :
            w_r[0] + shs_pkg::small_s0(w_r[1]) + w_r[9] + shs_pkg::small_s1(w_r[14]);
    t1 = v_r[7] + shs_pkg::big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + shs_pkg::ROUND_K[cnt_r] + w_cur;
    t2 = shs_pkg::big_s0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    byte_we  = 1'b0;
    byte_val = in_data_byte;
    if (state_r == shs_pkg::ST_IDLE) begin
      byte_we = in_acc && in_has_byte;
    end else if (state_r == shs_pkg::ST_PAD) begin
      byte_we = 1'b1;
      if (first_r) begin
        byte_val = shs_pkg::PAD_MARK;
      end else if (fill_r >= shs_pkg::LEN_POS && !extra_r) begin
        byte_val = len_shift[63:56];
      end else begin
        byte_val = 8'h00;
      end
    end
  end

  assign blk_we    = byte_we && (fill_r[1:0] == 2'b11);
  assign blk_waddr = fill_r[5:2];
  assign blk_wdata = {asm_r, byte_val};
  assign blk_raddr = (state_r == shs_pkg::ST_LDH) ? 4'd0 : (cnt_r[3:0] + 4'd1);

  always_comb begin
    ch_we    = 1'b0;
    ch_waddr = cnt_r[2:0];
    ch_wdata = shs_pkg::INIT_H[cnt_r[2:0]];
    ch_raddr = cnt_r[2:0];
    unique case (state_r)
      shs_pkg::ST_INIT: ch_we = 1'b1;
      shs_pkg::ST_ADD: begin
        ch_we    = (cnt_r != 6'd0);
        ch_waddr = cnt_r[2:0] - 3'd1;
        ch_wdata = ch_rdata + v_r[cnt_r[2:0] - 3'd1];
      end
      shs_pkg::ST_OLD: ch_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    fill_nxt   = fill_r;
    bitlen_nxt = bitlen_r;
    asm_nxt    = asm_r;
    fin_nxt    = fin_r;
    final_nxt  = final_r;
    first_nxt  = first_r;
    extra_nxt  = extra_r;
    if (byte_we) begin
      fill_nxt = fill_r + 6'd1;
      asm_nxt  = {asm_r[15:0], byte_val};
    end
    unique case (state_r)
      shs_pkg::ST_INIT: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd7) begin
          state_nxt = shs_pkg::ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      shs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            bitlen_nxt = bitlen_r + 64'd8;
          end
          if (in_last) begin
            fin_nxt   = 1'b1;
            first_nxt = 1'b1;
            state_nxt = shs_pkg::ST_PAD;
          end
          if (in_has_byte && fill_r == 6'd63) begin
            state_nxt = shs_pkg::ST_LDH;
            cnt_nxt   = '0;
          end
        end
      end
      shs_pkg::ST_PAD: begin
        first_nxt = 1'b0;
        if (first_r && fill_r >= shs_pkg::LEN_POS) begin
          extra_nxt = 1'b1;
        end
        if (fill_r == 6'd63) begin
          state_nxt = shs_pkg::ST_LDH;
          cnt_nxt   = '0;
          extra_nxt = 1'b0;
          final_nxt = !extra_r && !(first_r && fill_r >= shs_pkg::LEN_POS);
        end
      end
      shs_pkg::ST_LDH: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd8) begin
          state_nxt = shs_pkg::ST_RND;
          cnt_nxt   = '0;
        end
      end
      shs_pkg::ST_RND: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = shs_pkg::ST_ADD;
          cnt_nxt   = '0;
        end
      end
      shs_pkg::ST_ADD: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd8) begin
          cnt_nxt = '0;
          if (final_r) begin
            state_nxt = shs_pkg::ST_ORD;
          end else if (fin_r) begin
            state_nxt = shs_pkg::ST_PAD;
          end else begin
            state_nxt = shs_pkg::ST_IDLE;
          end
        end
      end
      shs_pkg::ST_ORD: begin
        if (!ovalid_r || out_ready) begin
          state_nxt = shs_pkg::ST_OLD;
        end
      end
      shs_pkg::ST_OLD: begin
        cnt_nxt   = cnt_r + 6'd1;
        state_nxt = shs_pkg::ST_ORD;
        if (cnt_r == 6'd7) begin
          cnt_nxt    = '0;
          state_nxt  = shs_pkg::ST_IDLE;
          fin_nxt    = 1'b0;
          final_nxt  = 1'b0;
          extra_nxt  = 1'b0;
          bitlen_nxt = '0;
          fill_nxt   = '0;
        end
      end
      default: state_nxt = shs_pkg::ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= shs_pkg::ST_INIT;
      cnt_r    <= '0;
      fill_r   <= '0;
      bitlen_r <= '0;
      fin_r    <= 1'b0;
      final_r  <= 1'b0;
      first_r  <= 1'b0;
      extra_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      fill_r   <= fill_nxt;
      bitlen_r <= bitlen_nxt;
      fin_r    <= fin_nxt;
      final_r  <= final_nxt;
      first_r  <= first_nxt;
      extra_r  <= extra_nxt;
      if (state_r == shs_pkg::ST_OLD) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
    if (state_r == shs_pkg::ST_LDH && cnt_r != 6'd0) begin
      for (int i = 0; i < 7; i++) begin
        v_r[i] <= v_r[i+1];
      end
      v_r[7] <= ch_rdata;
    end else if (state_r == shs_pkg::ST_RND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_cur;
    end
    if (state_r == shs_pkg::ST_OLD) begin
      oword_r <= ch_rdata;
      oidx_r  <= cnt_r[2:0];
      olast_r <= (cnt_r == 6'd7);
    end
  end

  assign out_valid       = ovalid_r;
  assign out_digest_word = oword_r;
  assign out_word_index  = oidx_r;
  assign out_last_word   = olast_r;

endmodule

/* hdl/shs_checker.sv */
// Port-level checker for the SHA-256 hasher and its bind to the top level.
// Depends on sha256_stream_hasher_top.
`timescale 1ns / 1ps

module shs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("stalled result changed");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last word flag does not match index");

  // No new request is taken while a digest is being read out.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=> !in_ready)
    else $error("request taken during digest output");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last_word)
    else $error("idle with a partial digest pending");

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_digest_word(out_digest_word),
  .out_word_index(out_word_index), .out_last_word(out_last_word)
);

/* tb/sv/testbench.sv */
// Testbench for the byte-serial SHA-256 hasher: drives byte requests with random gaps,
// predicts each digest with its own SHA-256 model in a scoreboard class and checks every word.
// Depends on shs_pkg (state type only indirectly) and sha256_stream_hasher_top.
`timescale 1ns / 1ps

class digest_board;
  localparam logic [31:0] IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KC [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] hash_h [0:7];
  logic [7:0]  blk [0:63];
  int          fill;
  logic [63:0] nbits;
  logic [31:0] pending_word [$];
  logic [2:0]  pending_index [$];
  logic        pending_last [$];
  int          errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) hash_h[i] = IV[i];
    fill = 0;
    nbits = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KC[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endfunction

  function void note_request(logic [7:0] data, logic has, logic fin);
    if (has) begin
      blk[fill] = data;
      fill++;
      nbits += 64'd8;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (!fin) return;
    blk[fill] = 8'h80;
    for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
    if (fill >= 56) begin
      compress();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) blk[63 - i] = nbits[8*i +: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      pending_word.push_back(hash_h[i]);
      pending_index.push_back(3'(i));
      pending_last.push_back(i == 7);
    end
    restart();
  endfunction

  function void check_word(logic [31:0] word, logic [2:0] idx, logic lst);
    logic [31:0] ew;
    logic [2:0]  ei;
    logic        el;
    if (pending_word.size() == 0) begin
      $display("%0t: unexpected digest word %h", $time, word);
      errors++;
      return;
    end
    ew = pending_word.pop_front();
    ei = pending_index.pop_front();
    el = pending_last.pop_front();
    if (word !== ew) begin
      $display("%0t: digest_word expected %h actual %h", $time, ew, word);
      errors++;
    end
    if (idx !== ei) begin
      $display("%0t: word_index expected %0d actual %0d", $time, ei, idx);
      errors++;
    end
    if (lst !== el) begin
      $display("%0t: last_word expected %0d actual %0d", $time, el, lst);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_board board;
  bit          sending_done;
  bit          hold_output;

  sha256_stream_hasher_top u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_request(logic [7:0] data, logic has, logic fin);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_has_byte <= has;
    in_last <= fin;
    do @(posedge clk); while (!in_ready);
    board.note_request(data, has, fin);
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit fin_alone);
    for (int i = 0; i < len; i++)
      send_request(8'($urandom), 1'b1, !fin_alone && i == len - 1);
    if (fin_alone || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_word.size() != 0) @(negedge clk);
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_has_byte = 1'b0;
    in_last = 1'b0;
    sending_done = 1'b0;
    hold_output = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h55, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'haa, 1'b0, 1'b0);
    send_request(8'h80, 1'b0, 1'b1);
    send_message(3, 1'b0);
    send_message(5, 1'b1);
    drain();

    hold_output = 1'b1;
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(64, 1'b0);
    hold_output = 1'b0;
    drain();
    repeat (40) @(negedge clk);

    for (int m = 0; m < 4; m++) begin
      case ($urandom_range(0, 5))
        0: send_message(0, 1'b1);
        1: send_request(8'($urandom), 1'($urandom), 1'b0);
        2: send_message($urandom_range(55, 65), 1'($urandom));
        default: send_message($urandom_range(1, 8), 1'($urandom));
      endcase
    end
    send_message(3, 1'b0);
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_output = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_word(out_digest_word, out_word_index, out_last_word);
    end
  end

  initial begin
    wait (sending_done);
    while (board.pending_word.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
